>>> rtl/core/fqr_pkg.sv
package fqr_pkg;

    localparam int DEPTH_DEFAULT        = 16;
    localparam int HANDLE_WIDTH_DEFAULT = 16;

    // Fixed widths of the channel fields.
    localparam int OP_W         = 2;
    localparam int HANDLE_IO_W  = 16;
    localparam int STATUS_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REMOVE  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain for one accepted beat.
    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
    } cell_cmd_t;

endpackage

>>> rtl/core/fqr_in_if.sv
interface fqr_in_if;
    import fqr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic [HANDLE_IO_W-1:0] handle;

    modport source (output valid, output op, output handle, input ready);
    modport sink   (input valid, input op, input handle, output ready);
endinterface

>>> rtl/core/fqr_out_if.sv
interface fqr_out_if;
    import fqr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [HANDLE_IO_W-1:0] handle_out;
    logic [STATUS_W-1:0]    status;
    logic                   now_empty;

    modport source (output valid, output handle_out, output status, output now_empty,
                    input ready);
    modport sink   (input valid, input handle_out, input status, input now_empty,
                    output ready);
endinterface

>>> rtl/core/fqr_cell.sv
module fqr_cell #(
    parameter int HANDLE_WIDTH = fqr_pkg::HANDLE_WIDTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fqr_pkg::cell_cmd_t      cmd,
    input  logic [HANDLE_WIDTH-1:0] key,
    input  logic                    prev_valid,
    input  logic                    next_valid,
    input  logic [HANDLE_WIDTH-1:0] next_data,
    input  logic                    hit_in,
    output logic                    hit_out,
    output logic                    valid,
    output logic [HANDLE_WIDTH-1:0] data
);
    import fqr_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    logic [HANDLE_WIDTH-1:0] data_reg;
    logic [HANDLE_WIDTH-1:0] data_next;
    logic                    match;

    assign match   = valid_reg && (data_reg == key);
    // Once the first match toward the head is seen, this cell and all cells
    // behind it pull from their tail-side neighbor to close the gap.
    assign hit_out = hit_in || match;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.enq && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            data_next  = key;
        end
        else if (cmd.deq || (cmd.rem && hit_out))
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> rtl/core/fifo_queue_with_removal_unit.sv
// Bounded first-in first-out queue of handles with delete by key.
// The cmd channel carries one operation per beat: op enqueue appends handle at
// the tail, op dequeue takes the head, op remove deletes the entry nearest the
// head that equals handle and closes the gap. Each cmd beat yields exactly one
// rsp beat with handle_out (dequeued handle, else zero), status (ok, empty,
// not found, full) and now_empty.
// The queue is a row of DEPTH cells, each holding one handle and a valid bit;
// all cells compare against the key in parallel and shift toward the head in
// the same cycle, so each operation updates the cells as its cmd beat is taken.
// Each rsp beat appears in the cycle after its cmd beat is accepted; a new cmd
// beat is taken in every cycle in which the rsp register is empty or being
// drained, giving one operation per cycle. When the receiver stalls, the rsp
// beat holds and cmd ready drops until it is taken.
// Reset clears all valid bits (empty queue) and the rsp valid bit; handle
// storage and the rsp fields are not reset.
module fifo_queue_with_removal_unit #(
    parameter int DEPTH        = fqr_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_WIDTH = fqr_pkg::HANDLE_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    fqr_in_if.sink     cmd,
    fqr_out_if.source  rsp
);
    import fqr_pkg::*;

    logic                    accept;
    cell_cmd_t               cell_cmd;
    logic [HANDLE_WIDTH-1:0] key;
    logic [DEPTH-1:0]        cell_valid;
    logic [HANDLE_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]        cell_hit;
    logic [HANDLE_IO_W-1:0]  head_handle;

    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic [HANDLE_IO_W-1:0]  handle_out_reg;
    logic [HANDLE_IO_W-1:0]  handle_out_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic                    now_empty_reg;
    logic                    now_empty_next;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    generate
        if (HANDLE_WIDTH > HANDLE_IO_W)
        begin : g_wide
            assign key         = {{(HANDLE_WIDTH-HANDLE_IO_W){1'b0}}, cmd.handle};
            assign head_handle = cell_data[0][HANDLE_IO_W-1:0];
        end
        else if (HANDLE_WIDTH == HANDLE_IO_W)
        begin : g_same
            assign key         = cmd.handle;
            assign head_handle = cell_data[0];
        end
        else
        begin : g_narrow
            assign key         = cmd.handle[HANDLE_WIDTH-1:0];
            assign head_handle = {{(HANDLE_IO_W-HANDLE_WIDTH){1'b0}}, cell_data[0]};
        end
    endgenerate

    always_comb
    begin
        cell_cmd     = '0;
        if (accept)
        begin
            unique case (cmd.op)
                OP_ENQUEUE: cell_cmd.enq = 1'b1;
                OP_DEQUEUE: cell_cmd.deq = 1'b1;
                OP_REMOVE:  cell_cmd.rem = 1'b1;
                default:    cell_cmd     = '0;
            endcase
        end
    end

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                    prev_valid;
            logic                    next_valid;
            logic [HANDLE_WIDTH-1:0] next_data;
            logic                    hit_in;

            if (i == 0)
            begin : g_head
                assign prev_valid = 1'b1;
                assign hit_in     = 1'b0;
            end
            else
            begin : g_body
                assign prev_valid = cell_valid[i-1];
                assign hit_in     = cell_hit[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign next_valid = 1'b0;
                assign next_data  = '0;
            end
            else
            begin : g_inner
                assign next_valid = cell_valid[i+1];
                assign next_data  = cell_data[i+1];
            end

            fqr_cell #(
                .HANDLE_WIDTH (HANDLE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cell_cmd),
                .key        (key),
                .prev_valid (prev_valid),
                .next_valid (next_valid),
                .next_data  (next_data),
                .hit_in     (hit_in),
                .hit_out    (cell_hit[i]),
                .valid      (cell_valid[i]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        handle_out_next = handle_out_reg;
        status_next     = status_reg;
        now_empty_next  = now_empty_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next  = 1'b1;
            handle_out_next = '0;
            status_next     = ST_OK;
            now_empty_next  = !cell_valid[0];
            case (cmd.op)
                OP_ENQUEUE:
                begin
                    if (cell_valid[DEPTH-1])
                    begin
                        status_next = ST_FULL;
                    end
                    now_empty_next = 1'b0;
                end
                OP_DEQUEUE:
                begin
                    if (!cell_valid[0])
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        handle_out_next = head_handle;
                        now_empty_next  = !cell_valid[1];
                    end
                end
                OP_REMOVE:
                begin
                    if (cell_hit[DEPTH-1])
                    begin
                        now_empty_next = !cell_valid[1];
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_out_reg <= handle_out_next;
        status_reg     <= status_next;
        now_empty_reg  <= now_empty_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.handle_out = handle_out_reg;
    assign rsp.status     = status_reg;
    assign rsp.now_empty  = now_empty_reg;

    // Occupied cells always form an unbroken run starting at the head.
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}) & {1'b0, cell_valid}) == '0)
        else $error("queue cells are not contiguous from the head");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("accepted beat produced no response");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.op == OP_ENQUEUE) && cell_valid[DEPTH-1]
        |=> (rsp.status == ST_FULL) && $stable(cell_valid))
        else $error("enqueue on a full queue was not rejected");

    a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.op == OP_DEQUEUE) && !cell_valid[0]
        |=> (rsp.status == ST_EMPTY) && rsp.now_empty && (rsp.handle_out == '0))
        else $error("dequeue on an empty queue reported wrongly");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.op == OP_REMOVE) && cell_hit[DEPTH-1]
        |=> $countones(cell_valid) + 1 == $countones($past(cell_valid)))
        else $error("successful remove did not drop exactly one entry");

endmodule

>>> verif/fifo_queue_with_removal_unit_test.sv
`timescale 1ns / 100ps

module fifo_queue_with_removal_unit_test;
    import fqr_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_OPS  = 1200;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [HANDLE_IO_W-1:0] handle_out;
        status_t                status;
        logic                   now_empty;
    } queue_reply_t;

    // Tracks the queue contents and the replies that the block still owes.
    class queue_scoreboard;
        logic [HANDLE_IO_W-1:0] held[$];
        queue_reply_t           owed[$];
        int                     mismatches = 0;

        function void note_cmd(logic [OP_W-1:0] op, logic [HANDLE_IO_W-1:0] handle);
            queue_reply_t r;
            int           hit;
            r.handle_out = '0;
            r.status     = ST_OK;
            hit          = -1;
            case (op)
                OP_ENQUEUE:
                begin
                    if (held.size() >= QUEUE_DEPTH)
                        r.status = ST_FULL;
                    else
                        held.push_back(handle);
                end
                OP_DEQUEUE:
                begin
                    if (held.size() == 0)
                        r.status = ST_EMPTY;
                    else
                        r.handle_out = held.pop_front();
                end
                OP_REMOVE:
                begin
                    // Only the match nearest the head goes away.
                    for (int i = 0; i < held.size(); i++)
                    begin
                        if (hit < 0 && held[i] == handle)
                            hit = i;
                    end
                    if (hit < 0)
                        r.status = ST_NOT_FOUND;
                    else
                        held.delete(hit);
                end
                default:
                begin
                end
            endcase
            r.now_empty = (held.size() == 0);
            owed.push_back(r);
        endfunction

        function void check_reply(logic [HANDLE_IO_W-1:0] handle_out,
                                  logic [STATUS_W-1:0] status, logic now_empty);
            queue_reply_t r;
            if (owed.size() == 0)
            begin
                $error("reply beat arrived with no command waiting");
                mismatches++;
                return;
            end
            r = owed.pop_front();
            if (handle_out !== r.handle_out)
            begin
                $error("handle_out: expected %h, actual %h", r.handle_out, handle_out);
                mismatches++;
            end
            if (status !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, status);
                mismatches++;
            end
            if (now_empty !== r.now_empty)
            begin
                $error("now_empty: expected %0d, actual %0d", r.now_empty, now_empty);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   send_idles = 1;
    bit   recv_stalls = 1;
    int   quiet_cycles = 0;

    queue_scoreboard sb;

    fqr_in_if  cmd_if ();
    fqr_out_if rsp_if ();

    fifo_queue_with_removal_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Receiver side: random back-pressure, switched off during the calm stretch.
    initial
    begin
        rsp_if.ready = 0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= !recv_stalls || ($urandom_range(99) >= 25);
        end
    end

    // Reply checker and watchdog on beats in either direction.
    initial
    begin
        sb = new();
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_reply(rsp_if.handle_out, rsp_if.status, rsp_if.now_empty);
            if ((rsp_if.valid && rsp_if.ready) || (cmd_if.valid && cmd_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [HANDLE_IO_W-1:0] handle);
        @(negedge clk);
        while (send_idles && $urandom_range(99) < 25)
        begin
            cmd_if.valid <= 0;
            @(negedge clk);
        end
        cmd_if.valid  <= 1;
        cmd_if.op     <= op;
        cmd_if.handle <= handle;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sb.note_cmd(op, handle);
    endtask

    task automatic drain_replies();
        @(negedge clk);
        cmd_if.valid <= 0;
        while (sb.owed.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [HANDLE_IO_W-1:0] pick_handle();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return HANDLE_IO_W'($urandom_range(7));
        else if (r < 70)
            return (r < 65) ? '0 : '1;
        else
            return HANDLE_IO_W'($urandom);
    endfunction

    task automatic directed_ops();
        send_cmd(OP_DEQUEUE, 16'h0000);
        send_cmd(OP_REMOVE, 16'h0000);
        send_cmd(OP_UNUSED, 16'hFFFF);
        send_cmd(OP_ENQUEUE, 16'hFFFF);
        send_cmd(OP_ENQUEUE, 16'h0000);
        send_cmd(OP_ENQUEUE, 16'h1234);
        send_cmd(OP_ENQUEUE, 16'h5A5A);
        send_cmd(OP_ENQUEUE, 16'h1234);
        for (int i = 5; i < QUEUE_DEPTH; i++)
            send_cmd(OP_ENQUEUE, HANDLE_IO_W'($urandom));
        send_cmd(OP_ENQUEUE, 16'hBEEF);
        send_cmd(OP_REMOVE, 16'h1234);
        send_cmd(OP_REMOVE, 16'hFFFF);
        send_cmd(OP_REMOVE, sb.held[sb.held.size() - 1]);
        send_cmd(OP_REMOVE, 16'hBEEF);
        send_cmd(OP_UNUSED, 16'h0000);
        send_cmd(OP_DEQUEUE, 16'hFFFF);
        send_cmd(OP_DEQUEUE, 16'h0000);
    endtask

    task automatic random_ops(input int count);
        int               done;
        int               r;
        int               enq_pct;
        logic [OP_W-1:0]  op;
        logic [HANDLE_IO_W-1:0] handle;
        done    = 0;
        enq_pct = 60;
        while (done < count)
        begin
            send_idles  = !(done >= 500 && done < 700);
            recv_stalls = send_idles;
            if (done == 300)
                drain_replies();
            // Alternate fill-heavy and drain-heavy phases so both ends of the
            // occupancy range get plenty of traffic.
            if (done % 40 == 0)
                enq_pct = (enq_pct == 60) ? 30 : 60;
            r = $urandom_range(99);
            if (r < 3)
                op = OP_UNUSED;
            else if ($urandom_range(99) < enq_pct)
                op = OP_ENQUEUE;
            else if ($urandom_range(1))
                op = OP_DEQUEUE;
            else
                op = OP_REMOVE;
            if (op == OP_REMOVE && sb.held.size() != 0 && $urandom_range(99) < 75)
                handle = sb.held[$urandom_range(sb.held.size() - 1)];
            else
                handle = pick_handle();
            send_cmd(op, handle);
            if (op != OP_UNUSED)
                done++;
        end
        send_idles  = 1;
        recv_stalls = 1;
    endtask

    initial
    begin
        rst_n         = 0;
        cmd_if.valid  = 0;
        cmd_if.op     = OP_ENQUEUE;
        cmd_if.handle = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        directed_ops();
        random_ops(RANDOM_OPS);
        drain_replies();
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
